// File: rtl/brs_pkg.sv
// Shared types and constants of the bilinear image resizer.
package brs_pkg;

  localparam int COORD_W    = 10;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int DIV_W      = 10;
  localparam int OUT_MAX    = 1024;
  localparam int CHAN_MAX   = 255;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_OUT_WIDTH  = 2'd2,
    CFG_OUT_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic clear;
    logic acc_en;
  } acc_ctrl_t;

endpackage

// File: rtl/bilinear_image_resize.sv
// Bilinear image resizer with its own source frame store. A load transaction writes one
// RGB pixel, or is dropped if its column or row lies outside the maximum source frame.
// A request transaction maps the output point onto the source grid with two bit-serial
// dividers running side by side, then reads the four neighbours one after another
// through the single read port of the frame store and blends them. No new transaction
// is taken until the result has entered the output register, which can wait for
// out_tready while the previous result still holds that register. A finished result
// sits in the output register, so the next transaction is taken while it waits. The
// frame store needs no clearing: each pixel must be loaded before a request reads it.
module bilinear_image_resize #(
  parameter int MAX_SRC_WIDTH  = 512,
  parameter int MAX_SRC_HEIGHT = 512,
  parameter int FRAC_BITS      = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // col[9:0], row[19:10], in_red[27:20], in_green[35:28], in_blue[43:36]
  input  logic [brs_pkg::IN_DATA_W-1:0]  in_tdata,
  // op
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_col[9:0], out_row[19:10], out_red[27:20], out_green[35:28], out_blue[43:36]
  output logic [brs_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_wr_en,
  input  logic [brs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [brs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import brs_pkg::*;

  localparam int XW    = $clog2(MAX_SRC_WIDTH);
  localparam int YW    = $clog2(MAX_SRC_HEIGHT);
  localparam int CW    = (XW > YW) ? XW : YW;
  localparam int PW    = COORD_W + CW;
  localparam int NW    = PW + FRAC_BITS;
  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WGT_W = 2 * FRAC_BITS + 1;

  localparam logic [AW-1:0]        W_A = AW'(MAX_SRC_WIDTH);
  localparam logic [FRAC_BITS:0]   ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_PREP, S_START, S_DIV, S_MAP, S_BASE, S_READ, S_LAST, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [9:0]              src_width_r, src_height_r;
  logic [10:0]             out_width_r, out_height_r;

  logic                    op_r;
  logic [COORD_W-1:0]      col_r, row_r;
  logic [PIX_W-1:0]        pix_r;

  logic [XW-1:0]           sxm1, smx_r, x0_r, x1_r;
  logic [YW-1:0]           sym1, smy_r, y0_r, y1_r;
  logic [DIV_W-1:0]        dx, dy, dx_r, dy_r;
  logic [PW-1:0]           px_r, py_r;
  logic [FRAC_BITS-1:0]    fx_r, fy_r;
  logic [AW-1:0]           base0_r, base1_r;
  logic [1:0]              k_r;
  logic [WGT_W-1:0]        wgt_r;
  logic                    acc_en_r;

  logic                    div_x_busy, div_y_busy;
  logic [NW-1:0]           qx, qy;
  logic [PW-1:0]           idx_x, idx_y;

  logic                    in_acc;
  logic                    ld_in_range;
  logic                    mem_wr_en, mem_rd_en;
  logic [AW-1:0]           ld_addr, rd_addr;
  logic [PIX_W-1:0]        rd_data;
  logic [FRAC_BITS:0]      wx, wy;
  logic [2*FRAC_BITS+1:0]  wprod;
  acc_ctrl_t               acc_ctrl;
  logic [2:0][CHAN_W-1:0]  chan;

  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= 10'd224;
      src_height_r <= 10'd224;
      out_width_r  <= 11'd350;
      out_height_r <= 11'd350;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata[9:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_wdata[9:0];
        CFG_OUT_WIDTH:  out_width_r  <= cfg_wdata;
        CFG_OUT_HEIGHT: out_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (src_width_r < 10'd2) begin
      sxm1 = XW'(1);
    end else if (32'(src_width_r) > MAX_SRC_WIDTH) begin
      sxm1 = XW'(MAX_SRC_WIDTH - 1);
    end else begin
      sxm1 = XW'(src_width_r - 10'd1);
    end
    if (src_height_r < 10'd2) begin
      sym1 = YW'(1);
    end else if (32'(src_height_r) > MAX_SRC_HEIGHT) begin
      sym1 = YW'(MAX_SRC_HEIGHT - 1);
    end else begin
      sym1 = YW'(src_height_r - 10'd1);
    end
    if (out_width_r < 11'd2) begin
      dx = DIV_W'(1);
    end else if (out_width_r > 11'(OUT_MAX)) begin
      dx = DIV_W'(OUT_MAX - 1);
    end else begin
      dx = DIV_W'(out_width_r - 11'd1);
    end
    if (out_height_r < 11'd2) begin
      dy = DIV_W'(1);
    end else if (out_height_r > 11'(OUT_MAX)) begin
      dy = DIV_W'(OUT_MAX - 1);
    end else begin
      dy = DIV_W'(out_height_r - 11'd1);
    end
  end

  brs_div #(.NUM_W(NW), .DEN_W(DIV_W)) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_START),
    .num   ({px_r, {FRAC_BITS{1'b0}}}),
    .den   (dx_r),
    .busy  (div_x_busy),
    .quot  (qx)
  );

  brs_div #(.NUM_W(NW), .DEN_W(DIV_W)) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_START),
    .num   ({py_r, {FRAC_BITS{1'b0}}}),
    .den   (dy_r),
    .busy  (div_y_busy),
    .quot  (qy)
  );

  assign idx_x = qx[NW-1:FRAC_BITS];
  assign idx_y = qy[NW-1:FRAC_BITS];

  always_comb begin
    ld_in_range = (32'(col_r) < MAX_SRC_WIDTH) && (32'(row_r) < MAX_SRC_HEIGHT);
    ld_addr     = AW'(row_r) * W_A + AW'(col_r);
    mem_wr_en   = (state_r == S_LOAD) && ld_in_range;
    mem_rd_en   = (state_r == S_READ);
    rd_addr     = (k_r[1] ? base1_r : base0_r) + AW'(k_r[0] ? x1_r : x0_r);
    wx          = k_r[0] ? {1'b0, fx_r} : ONE - {1'b0, fx_r};
    wy          = k_r[1] ? {1'b0, fy_r} : ONE - {1'b0, fy_r};
    wprod       = (2*FRAC_BITS+2)'(wx) * (2*FRAC_BITS+2)'(wy);
  end

  brs_frame_store #(.DEPTH(DEPTH), .ADDR_W(AW)) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (ld_addr),
    .wr_data (pix_r),
    .rd_en   (mem_rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign acc_ctrl = '{clear: (state_r == S_BASE), acc_en: acc_en_r};

  brs_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk    (clk),
    .ctrl   (acc_ctrl),
    .weight (wgt_r),
    .pixel  (rd_data),
    .chan   (chan)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == OP_LOAD) ? S_LOAD : S_PREP;
        end
      end
      S_LOAD:  state_nxt = S_IDLE;
      S_PREP:  state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV: begin
        if (!div_x_busy && !div_y_busy) begin
          state_nxt = S_MAP;
        end
      end
      S_MAP:  state_nxt = S_BASE;
      S_BASE: state_nxt = S_READ;
      S_READ: begin
        if (k_r == 2'd3) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_en_r <= (state_r == S_READ);

      if (in_acc) begin
        op_r  <= in_tuser;
        col_r <= in_tdata[9:0];
        row_r <= in_tdata[19:10];
        pix_r <= {in_tdata[27:20], in_tdata[35:28], in_tdata[43:36]};
      end

      if (state_r == S_PREP) begin
        px_r  <= PW'(col_r) * PW'(sxm1);
        py_r  <= PW'(row_r) * PW'(sym1);
        dx_r  <= dx;
        dy_r  <= dy;
        smx_r <= sxm1;
        smy_r <= sym1;
      end

      if (state_r == S_MAP) begin
        x0_r <= (idx_x > PW'(smx_r)) ? smx_r : XW'(idx_x);
        x1_r <= (idx_x >= PW'(smx_r)) ? smx_r : XW'(idx_x + PW'(1));
        y0_r <= (idx_y > PW'(smy_r)) ? smy_r : YW'(idx_y);
        y1_r <= (idx_y >= PW'(smy_r)) ? smy_r : YW'(idx_y + PW'(1));
        fx_r <= qx[FRAC_BITS-1:0];
        fy_r <= qy[FRAC_BITS-1:0];
      end

      if (state_r == S_BASE) begin
        base0_r <= AW'(y0_r) * W_A;
        base1_r <= AW'(y1_r) * W_A;
        k_r     <= 2'd0;
      end

      if (state_r == S_READ) begin
        wgt_r <= wprod[WGT_W-1:0];
        k_r   <= k_r + 2'd1;
      end

      if ((state_r == S_OUT) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {4'b0, chan[0], chan[1], chan[2], row_r, col_r};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_store_port_shared: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en))
    else $error("frame store written and read in one cycle");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    div_x_busy == div_y_busy)
    else $error("coordinate dividers out of step");

  a_acc_window: assert property (@(posedge clk) disable iff (!rst_n)
    acc_en_r |-> (state_r == S_READ || state_r == S_LAST))
    else $error("accumulation outside the neighbour read window");

  a_neighbour_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BASE) |-> (x1_r <= smx_r && y1_r <= smy_r && x0_r <= x1_r && y0_r <= y1_r))
    else $error("neighbour index beyond the source frame");

  a_request_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PREP) |-> (op_r == OP_REQUEST))
    else $error("load transaction entered the resample path");
`endif

endmodule

// File: rtl/brs_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module brs_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      quo_r  <= num;
      rem_r  <= '0;
      den_r  <= den;
      cnt_r  <= CNT_W'(NUM_W);
      busy_r <= 1'b1;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;

endmodule

// File: rtl/brs_frame_store.sv
// Source frame memory: one write port, one registered read port.
module brs_frame_store #(
  parameter int DEPTH  = 262144,
  parameter int ADDR_W = 18
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [brs_pkg::PIX_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [brs_pkg::PIX_W-1:0] rd_data
);

  import brs_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/brs_blend.sv
// Per-channel weighted accumulation of the four neighbours and saturation.
module brs_blend #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  brs_pkg::acc_ctrl_t                    ctrl,
  input  logic [2*FRAC_BITS:0]                  weight,
  input  logic [brs_pkg::PIX_W-1:0]             pixel,
  output logic [2:0][brs_pkg::CHAN_W-1:0]       chan
);

  import brs_pkg::*;

  localparam int ACC_W = 2 * FRAC_BITS + CHAN_W + 1;
  localparam int V_W   = ACC_W - 2 * FRAC_BITS;

  logic [ACC_W-1:0] acc_r [3];
  logic [ACC_W-1:0] prod  [3];
  logic [V_W-1:0]   v     [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = ACC_W'(pixel[c*CHAN_W +: CHAN_W]) * ACC_W'(weight);
      v[c]    = acc_r[c][ACC_W-1:2*FRAC_BITS];
      chan[c] = (v[c] > V_W'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX) : v[c][CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (ctrl.clear) begin
        acc_r[c] <= '0;
      end else if (ctrl.acc_en) begin
        acc_r[c] <= acc_r[c] + prod[c];
      end
    end
  end

endmodule

// File: bench/tb_bilinear_image_resize.sv
// Self-checking testbench for the bilinear image resizer: loads, requests and size settings.
module tb_bilinear_image_resize;
  import brs_pkg::*;

  localparam int SRC_W_MAX   = 512;
  localparam int SRC_H_MAX   = 512;
  localparam int FRAC_W      = 8;
  localparam int ONE         = 1 << FRAC_W;
  localparam int SETTLE_CYC  = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 170;

  typedef struct packed {
    bit [9:0] col;
    bit [9:0] row;
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
  } pixel_t;

  class resize_checker;
    bit [23:0]  frame [int];
    pixel_t     pending_pixels [$];
    bit [10:0]  size_reg [4];
    int         errors;
    int         loads_kept;
    int         loads_dropped;
    int         requests;
    int         checked;

    function new();
      size_reg[CFG_SRC_WIDTH]  = 11'd224;
      size_reg[CFG_SRC_HEIGHT] = 11'd224;
      size_reg[CFG_OUT_WIDTH]  = 11'd350;
      size_reg[CFG_OUT_HEIGHT] = 11'd350;
    endfunction

    function void set_size(cfg_idx_t idx, bit [10:0] val);
      if (idx == CFG_SRC_WIDTH || idx == CFG_SRC_HEIGHT) begin
        size_reg[idx] = val & 11'h3FF;
      end else begin
        size_reg[idx] = val;
      end
    endfunction

    function int unsigned used_size(cfg_idx_t idx);
      int unsigned hi;
      int unsigned v;
      hi = (idx == CFG_SRC_WIDTH) ? SRC_W_MAX : (idx == CFG_SRC_HEIGHT) ? SRC_H_MAX : OUT_MAX;
      v = 32'(size_reg[idx]);
      if (v < 2) v = 2;
      if (v > hi) v = hi;
      return v;
    endfunction

    function void map_axis(input int unsigned pos, input int unsigned src,
                           input int unsigned span, output int unsigned i0,
                           output int unsigned i1, output int unsigned fr);
      int unsigned d;
      int unsigned p;
      int unsigned idx;
      d   = span - 1;
      p   = pos * (src - 1);
      idx = p / d;
      fr  = ((p % d) << FRAC_W) / d;
      i0  = (idx > src - 1) ? src - 1 : idx;
      i1  = (idx + 1 > src - 1) ? src - 1 : idx + 1;
    endfunction

    function bit is_loaded(int unsigned x, int unsigned y);
      return frame.exists(y * SRC_W_MAX + x);
    endfunction

    function bit [23:0] stored_at(int unsigned x, int unsigned y);
      return is_loaded(x, y) ? frame[y * SRC_W_MAX + x] : 24'd0;
    endfunction

    function pixel_t blend_pixel(bit [9:0] col, bit [9:0] row);
      int unsigned       x0, x1, fx, y0, y1, fy;
      bit [23:0]         p [4];
      longint unsigned   w [4];
      longint unsigned   s;
      bit [7:0]          ch [3];
      pixel_t            r;
      map_axis(32'(col), used_size(CFG_SRC_WIDTH), used_size(CFG_OUT_WIDTH), x0, x1, fx);
      map_axis(32'(row), used_size(CFG_SRC_HEIGHT), used_size(CFG_OUT_HEIGHT), y0, y1, fy);
      p[0] = stored_at(x0, y0);
      p[1] = stored_at(x1, y0);
      p[2] = stored_at(x0, y1);
      p[3] = stored_at(x1, y1);
      w[0] = 64'((ONE - fx) * (ONE - fy));
      w[1] = 64'(fx * (ONE - fy));
      w[2] = 64'((ONE - fx) * fy);
      w[3] = 64'(fx * fy);
      for (int c = 0; c < 3; c++) begin
        s = 0;
        for (int k = 0; k < 4; k++) s += longint'(p[k][16 - 8 * c +: 8]) * w[k];
        s = s >> (2 * FRAC_W);
        ch[c] = (s > CHAN_MAX) ? 8'(CHAN_MAX) : s[7:0];
      end
      r.col   = col;
      r.row   = row;
      r.red   = ch[0];
      r.green = ch[1];
      r.blue  = ch[2];
      return r;
    endfunction

    function void note_item(bit op, bit [47:0] data);
      bit [9:0] col;
      bit [9:0] row;
      col = data[9:0];
      row = data[19:10];
      if (op == OP_LOAD) begin
        if (col < SRC_W_MAX && row < SRC_H_MAX) begin
          frame[row * SRC_W_MAX + col] = {data[27:20], data[35:28], data[43:36]};
          loads_kept++;
        end else begin
          loads_dropped++;
        end
      end else begin
        pending_pixels.push_back(blend_pixel(col, row));
        requests++;
      end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(bit [47:0] data);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: out_col %0d out_row %0d", data[9:0], data[19:10]);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      checked++;
      check_field("out_col", 32'(want.col), 32'(data[9:0]));
      check_field("out_row", 32'(want.row), 32'(data[19:10]));
      check_field("out_red", 32'(want.red), 32'(data[27:20]));
      check_field("out_green", 32'(want.green), 32'(data[35:28]));
      check_field("out_blue", 32'(want.blue), 32'(data[43:36]));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  resize_checker sb = new();
  int  items_done;
  int  settings_used;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  hold_request;

  bilinear_image_resize u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(out_tdata);
  end

  // hold off the result side on request, otherwise stall at random while rx_idle_on is set
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      out_tready = rx_idle_on ? ($urandom_range(99) >= 32) : 1'b1;
    end
  end

  function automatic bit [7:0] rand_chan();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  function automatic bit [9:0] out_coord(int unsigned span);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) return 10'($urandom_range(span - 1));
    if (pick < 92) return 10'($urandom_range(1023));
    return 10'(span - 1);
  endfunction

  task automatic send_item(bit op, bit [9:0] col, bit [9:0] row,
                           bit [7:0] r, bit [7:0] g, bit [7:0] b);
    @(negedge clk);
    while (tx_idle_on && $urandom_range(99) < 32) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {4'd0, b, g, r, row, col};
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, in_tdata);
  endtask

  task automatic load_pixel(bit [9:0] col, bit [9:0] row,
                            bit [7:0] r, bit [7:0] g, bit [7:0] b);
    send_item(OP_LOAD, col, row, r, g, b);
    if (col < SRC_W_MAX && row < SRC_H_MAX) items_done++;
  endtask

  // load any neighbour not yet written, then request the pixel
  task automatic ask_pixel(bit [9:0] col, bit [9:0] row);
    int unsigned x0, x1, fx, y0, y1, fy;
    int unsigned xs [4];
    int unsigned ys [4];
    sb.map_axis(32'(col), sb.used_size(CFG_SRC_WIDTH), sb.used_size(CFG_OUT_WIDTH),
                x0, x1, fx);
    sb.map_axis(32'(row), sb.used_size(CFG_SRC_HEIGHT), sb.used_size(CFG_OUT_HEIGHT),
                y0, y1, fy);
    xs = '{x0, x1, x0, x1};
    ys = '{y0, y0, y1, y1};
    for (int k = 0; k < 4; k++) begin
      if (!sb.is_loaded(xs[k], ys[k]))
        load_pixel(10'(xs[k]), 10'(ys[k]), rand_chan(), rand_chan(), rand_chan());
    end
    send_item(OP_REQUEST, col, row, rand_chan(), rand_chan(), rand_chan());
    items_done++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, bit [10:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_size(idx, val);
  endtask

  task automatic set_sizes(bit [10:0] sw, bit [10:0] sh, bit [10:0] ow, bit [10:0] oh);
    settle();
    cfg_write(CFG_SRC_WIDTH, sw);
    cfg_write(CFG_SRC_HEIGHT, sh);
    cfg_write(CFG_OUT_WIDTH, ow);
    cfg_write(CFG_OUT_HEIGHT, oh);
    settings_used++;
  endtask

  task automatic random_phase(int budget);
    int          start;
    int unsigned pick;
    int unsigned ow, oh, lim_c, lim_r;
    start = items_done;
    while (items_done - start < budget) begin
      ow   = sb.used_size(CFG_OUT_WIDTH);
      oh   = sb.used_size(CFG_OUT_HEIGHT);
      pick = $urandom_range(99);
      if (pick < 70) begin
        ask_pixel(out_coord(ow), out_coord(oh));
      end else if (pick < 88) begin
        lim_c = sb.used_size(CFG_SRC_WIDTH) + 3;
        lim_r = sb.used_size(CFG_SRC_HEIGHT) + 3;
        if (lim_c > SRC_W_MAX - 1) lim_c = SRC_W_MAX - 1;
        if (lim_r > SRC_H_MAX - 1) lim_r = SRC_H_MAX - 1;
        load_pixel(10'($urandom_range(lim_c)), 10'($urandom_range(lim_r)),
                   rand_chan(), rand_chan(), rand_chan());
      end else if (pick < 94) begin
        if ($urandom_range(1))
          load_pixel(10'($urandom_range(1023, SRC_W_MAX)), 10'($urandom_range(1023)),
                     rand_chan(), rand_chan(), rand_chan());
        else
          load_pixel(10'($urandom_range(SRC_W_MAX - 1)), 10'($urandom_range(1023, SRC_H_MAX)),
                     rand_chan(), rand_chan(), rand_chan());
      end else begin
        ask_pixel($urandom_range(1) ? 10'(ow - 1) : 10'd1023,
                  $urandom_range(1) ? 10'd0 : 10'(oh - 1));
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = OP_LOAD;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_addr   = CFG_SRC_WIDTH;
    cfg_wdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    settings_used = 1;

    load_pixel(10'd0, 10'd0, 8'd255, 8'd255, 8'd255);
    load_pixel(10'd1, 10'd0, 8'd0, 8'd0, 8'd0);
    load_pixel(10'd0, 10'd1, 8'd255, 8'd0, 8'd128);
    load_pixel(10'd1, 10'd1, 8'd0, 8'd255, 8'd127);
    ask_pixel(10'd0, 10'd0);
    ask_pixel(10'd1, 10'd1);
    load_pixel(10'd223, 10'd223, 8'd200, 8'd100, 8'd50);
    ask_pixel(10'd349, 10'd349);
    ask_pixel(10'd1023, 10'd1023);
    ask_pixel(10'd348, 10'd348);
    ask_pixel(10'd1023, 10'd0);
    ask_pixel(10'd0, 10'd1023);
    load_pixel(10'd511, 10'd511, 8'd170, 8'd85, 8'd255);
    load_pixel(10'd1023, 10'd1023, 8'd255, 8'd255, 8'd255);
    load_pixel(10'd512, 10'd3, 8'd1, 8'd2, 8'd3);
    load_pixel(10'd3, 10'd512, 8'd4, 8'd5, 8'd6);

    hold_request = 1'b1;
    random_phase(PHASE_ITEMS);

    set_sizes(11'd2, 11'd2, 11'd2, 11'd2);
    random_phase(PHASE_ITEMS);

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_sizes(11'd1023, 11'd1023, 11'd2047, 11'd2047);
    random_phase(PHASE_ITEMS);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    set_sizes(11'd0, 11'd1, 11'd1, 11'd0);
    random_phase(PHASE_ITEMS);

    set_sizes(11'd512, 11'd2, 11'd1024, 11'd3);
    random_phase(PHASE_ITEMS);

    set_sizes(11'd100, 11'd60, 11'd37, 11'd20);
    random_phase(PHASE_ITEMS);

    set_sizes(11'd17, 11'd300, 11'd700, 11'd5);
    random_phase(PHASE_ITEMS);

    repeat (3) begin
      set_sizes(11'($urandom_range(1023)), 11'($urandom_range(1023)),
                11'($urandom_range(2047)), 11'($urandom_range(2047)));
      random_phase(PHASE_ITEMS);
    end

    settle();

    $display("Covered %0d stored loads, %0d dropped loads and %0d requests over %0d size settings.",
             sb.loads_kept, sb.loads_dropped, sb.requests, settings_used);
    $display("Compared %0d interpolated pixels, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/brs_pkg.sv
rtl/brs_div.sv
rtl/brs_frame_store.sv
rtl/brs_blend.sv
rtl/bilinear_image_resize.sv
bench/tb_bilinear_image_resize.sv
